### hdl/csub_pkg.sv
package csub_pkg;

	// field widths of one pixel and one result
	localparam int SAMPLE_W     = 8;
	localparam int CCOL_W       = 11;
	localparam int LINE_WIDTH_W = 13;

	// stream word widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 2;

	// bit positions in the output word and user bits
	localparam int M_CB_LSB   = 8;
	localparam int M_CCOL_MSB = 34;
	localparam int M_USER_VLD = 0;
	localparam int M_USER_FIN = 1;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LINE_WIDTH_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH     = 1'b0,
		REG_SUBSAMPLE_MODE = 1'b1
	} cfg_reg_t;

	// subsample mode codes
	localparam logic MODE_422 = 1'b0;
	localparam logic MODE_420 = 1'b1;

	// defaults
	localparam int   DEF_MAX_LINE_WIDTH = 4096;
	localparam int   LINE_WIDTH_RESET   = 1920;
	localparam logic MODE_RESET         = MODE_420;

endpackage

### hdl/chroma_subsample_444_to_420.sv
// channel   dir  handshake                      payload (lowest bit first)
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: luma, cb, cr; tuser: odd_row
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: luma, cb, cr, chroma_column;
//                                               tuser: chroma_valid, chroma_final
// cfg       in   cfg_wr_en (no wait)            cfg_index, cfg_data
//
// one pixel per clock sustained while m_axis does not stall; a word passes the compute stage, then the output register.
// the chroma line store has one port pair: the read goes out when a pair pixel of an odd 4:2:0 row is
// taken, the write back happens when a 4:2:0 pair word leaves the compute stage.
// reset clears counters and handshake state; the line store is not cleared.
// a stall on m_axis holds both stages; s_axis keeps taking words while a stage is free.
module chroma_subsample_444_to_420 #(
	parameter int MAX_LINE_WIDTH = csub_pkg::DEF_MAX_LINE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [csub_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csub_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [csub_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // luma_in, cb_in, cr_in
	input  logic [csub_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // odd_row
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [csub_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // luma_out, cb_out, cr_out,
	                                                          // chroma_column, zero pad
	output logic [csub_pkg::M_TUSER_W-1:0]     m_axis_tuser   // chroma_valid, chroma_final
);
	import csub_pkg::*;

	localparam int CW    = $clog2(MAX_LINE_WIDTH);
	localparam int AW    = (CW > 1) ? CW - 1 : 1;
	localparam int DEPTH = 1 << AW;
	localparam int WW    = (CW + 1 > LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W;
	localparam int RST_W = (LINE_WIDTH_RESET > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH
		: LINE_WIDTH_RESET;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_LINE_WIDTH);

	typedef struct packed {
		logic                pair;
		logic                mode;
		logic                odd_row;
		logic [SAMPLE_W-1:0] luma;
		logic [SAMPLE_W-1:0] cb_avg;
		logic [SAMPLE_W-1:0] cr_avg;
		logic [CCOL_W-1:0]   ccol;
		logic [AW-1:0]       addr;
	} stage_t;

	logic [WW-1:0]       width_q;
	logic                mode_q;
	logic [WW-1:0]       width_cfg;
	logic [WW-1:0]       width_raw;
	logic [CW-1:0]       col_q;
	logic [WW-1:0]       col_inc;
	logic [SAMPLE_W-1:0] cb_pend_q;
	logic [SAMPLE_W-1:0] cr_pend_q;
	logic [SAMPLE_W-1:0] in_luma;
	logic [SAMPLE_W-1:0] in_cb;
	logic [SAMPLE_W-1:0] in_cr;
	logic                in_odd;
	logic                s_acc;
	logic                is_pair;
	logic [SAMPLE_W:0]   cb_sum;
	logic [SAMPLE_W:0]   cr_sum;
	logic                advance;
	logic                valid_s1;
	stage_t              st_s1;
	stage_t              st_in;
	logic [2*SAMPLE_W-1:0] mem [DEPTH];
	logic [2*SAMPLE_W-1:0] mem_rd_q;
	logic                rd_en;
	logic                wr_en;
	logic [2*SAMPLE_W-1:0] wr_data;
	logic [SAMPLE_W:0]   cb_mix;
	logic [SAMPLE_W:0]   cr_mix;
	logic [SAMPLE_W-1:0] cb_res;
	logic [SAMPLE_W-1:0] cr_res;
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic [M_TUSER_W-1:0] m_user_q;

	// configuration, line width clamped to 1..max on write
	always_comb begin
		width_raw = WW'(cfg_data);
		if (width_raw == '0) begin
			width_cfg = WW'(1);
		end else if (width_raw > MAX_W) begin
			width_cfg = MAX_W;
		end else begin
			width_cfg = width_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(RST_W);
			mode_q  <= MODE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_WIDTH:     width_q <= width_cfg;
				REG_SUBSAMPLE_MODE: mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input word unpacking
	assign in_luma = s_axis_tdata[SAMPLE_W-1:0];
	assign in_cb   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign in_cr   = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
	assign in_odd  = s_axis_tuser[0];

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// horizontal pair average and column counter
	assign is_pair = col_q[0];
	assign cb_sum  = {1'b0, cb_pend_q} + {1'b0, in_cb};
	assign cr_sum  = {1'b0, cr_pend_q} + {1'b0, in_cr};
	assign col_inc = WW'(col_q) + WW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			cb_pend_q <= '0;
			cr_pend_q <= '0;
		end else if (s_acc) begin
			col_q <= (col_inc >= width_q) ? '0 : CW'(col_inc);
			if (!is_pair) begin
				cb_pend_q <= in_cb;
				cr_pend_q <= in_cr;
			end
		end
	end

	always_comb begin
		st_in.pair    = is_pair;
		st_in.mode    = mode_q;
		st_in.odd_row = in_odd;
		st_in.luma    = in_luma;
		st_in.cb_avg  = cb_sum[SAMPLE_W:1];
		st_in.cr_avg  = cr_sum[SAMPLE_W:1];
		st_in.ccol    = CCOL_W'(col_q >> 1);
		st_in.addr    = AW'(col_q >> 1);
	end

	// compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			st_s1 <= st_in;
		end
	end

	// line store: read on a pair pixel of an odd row, write back when the word moves on.
	// pair columns alternate with unpaired ones, so the word in the compute stage and
	// the word being taken never touch the store together
	assign rd_en = s_acc && is_pair && (mode_q == MODE_420) && in_odd;
	assign wr_en = valid_s1 && advance && st_s1.pair && (st_s1.mode == MODE_420);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[st_s1.addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[st_in.addr];
		end
	end

	// vertical average against the stored even-row value
	assign cb_mix = {1'b0, st_s1.cb_avg} + {1'b0, mem_rd_q[SAMPLE_W-1:0]};
	assign cr_mix = {1'b0, st_s1.cr_avg} + {1'b0, mem_rd_q[2*SAMPLE_W-1:SAMPLE_W]};

	always_comb begin
		if (st_s1.mode == MODE_420 && st_s1.odd_row) begin
			cb_res = cb_mix[SAMPLE_W:1];
			cr_res = cr_mix[SAMPLE_W:1];
		end else begin
			cb_res = st_s1.cb_avg;
			cr_res = st_s1.cr_avg;
		end
	end

	assign wr_data = {cr_res, cb_res};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (st_s1.pair) begin
				m_data_q <= M_TDATA_W'({st_s1.ccol, cr_res, cb_res, st_s1.luma});
				m_user_q <= {(st_s1.mode == MODE_422) || st_s1.odd_row, 1'b1};
			end else begin
				m_data_q <= M_TDATA_W'(st_s1.luma);
				m_user_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

### hdl/csub_check.sv
module csub_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [csub_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // luma, cb, cr, chroma_column
	input logic [csub_pkg::M_TUSER_W-1:0]     m_axis_tuser   // chroma_valid, chroma_final
);
	import csub_pkg::*;

	logic       s_acc;
	logic       m_acc;
	logic [1:0] inflight_q;
	logic       prev_pair_q;

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;

	// words inside the block and pairing of the last word out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			prev_pair_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 2'(s_acc) - 2'(m_acc);
			if (m_acc) begin
				prev_pair_q <= m_axis_tuser[M_USER_VLD];
			end
		end
	end

	// a word out needs a word in
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc |-> inflight_q != 2'd0) else $error("output word without input word");

	// two pipeline stages hold at most two words
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3) else $error("more words in flight than stages");

	// two paired results never follow each other
	a_alternate: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && m_axis_tuser[M_USER_VLD] |-> !prev_pair_q)
		else $error("two chroma pairs in a row");

	// unpaired word carries no chroma
	a_unpaired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[M_USER_VLD] |->
		!m_axis_tuser[M_USER_FIN] && m_axis_tdata[M_CCOL_MSB:M_CB_LSB] == '0)
		else $error("chroma on unpaired word");

	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser)) else $error("output changed under stall");

endmodule

bind chroma_subsample_444_to_420 csub_check u_csub_check (.*);

### tb/chroma_subsample_444_to_420_tb.sv
`timescale 1ns / 100ps

module chroma_subsample_444_to_420_tb;
	import csub_pkg::*;

	localparam int MAX_W        = DEF_MAX_LINE_WIDTH;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_LIMIT = 10;

	// one 4:4:4 pixel as offered on s_axis
	typedef struct packed {
		logic                odd;
		logic [SAMPLE_W-1:0] cr;
		logic [SAMPLE_W-1:0] cb;
		logic [SAMPLE_W-1:0] luma;
	} pixel_t;

	// m_axis tdata layout, lowest field last
	typedef struct packed {
		logic [M_TDATA_W-CCOL_W-3*SAMPLE_W-1:0] pad;
		logic [CCOL_W-1:0]                      ccol;
		logic [SAMPLE_W-1:0]                    cr;
		logic [SAMPLE_W-1:0]                    cb;
		logic [SAMPLE_W-1:0]                    luma;
	} out_data_t;

	typedef struct packed {
		logic      fin;
		logic      vld;
		out_data_t data;
	} chroma_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_LINE_WIDTH;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [S_TDATA_W-1:0]    s_axis_tdata  = '0;  // luma_in, cb_in, cr_in
	logic [S_TUSER_W-1:0]    s_axis_tuser  = '0;  // odd_row
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]    m_axis_tdata;        // luma_out, cb_out, cr_out, chroma_column, pad
	logic [M_TUSER_W-1:0]    m_axis_tuser;        // chroma_valid, chroma_final

	chroma_subsample_444_to_420 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// queues and counters
	pixel_t       pixel_q[$];
	chroma_word_t chroma_q[$];
	pixel_t       offered;
	int           pushed_total  = 0;
	int           words_in      = 0;
	int           words_out     = 0;
	int           fails         = 0;
	int           provisional_n = 0;
	int           final_n       = 0;
	int           settings_n    = 0;
	int           send_idle_pct = 16;
	int           recv_idle_pct = 71;
	bit           hold_armed    = 1'b0;
	bit           hold_done     = 1'b0;
	int           hold_left     = 0;
	int           stall_cycles  = 0;

	// predictor state
	logic [LINE_WIDTH_W-1:0] pr_width = LINE_WIDTH_RESET;
	logic                    pr_mode  = MODE_RESET;
	logic [LINE_WIDTH_W-1:0] pr_col   = '0;
	logic [SAMPLE_W-1:0]     pr_cb_hold = '0;
	logic [SAMPLE_W-1:0]     pr_cr_hold = '0;
	logic [15:0]             pr_store [1 << CCOL_W];

	// generator shadow: column position, row parity, which store entries hold data
	logic [LINE_WIDTH_W-1:0] gen_width = LINE_WIDTH_RESET;
	logic                    gen_mode  = MODE_RESET;
	logic [LINE_WIDTH_W-1:0] gen_col   = '0;
	logic                    gen_odd   = 1'b0;
	bit                      store_filled [1 << CCOL_W];

	// column counter step, with the width clamped to 1..MAX_W
	function automatic logic [LINE_WIDTH_W-1:0] column_after(logic [LINE_WIDTH_W-1:0] col,
		logic [LINE_WIDTH_W-1:0] width);
		int eff;
		eff = width;
		if (eff < 1)
			eff = 1;
		if (eff > MAX_W)
			eff = MAX_W;
		if (int'(col) + 1 >= eff)
			return '0;
		return col + 1'b1;
	endfunction

	// expected output word for one pixel; advances the predictor state
	function automatic chroma_word_t chroma_predict(pixel_t px);
		chroma_word_t      r;
		logic [CCOL_W-1:0] idx;
		logic [8:0]        cb_sum, cr_sum;
		logic [15:0]       entry;
		r = '0;
		r.data.luma = px.luma;
		idx = pr_col[CCOL_W:1];
		if (!pr_col[0]) begin
			pr_cb_hold = px.cb;
			pr_cr_hold = px.cr;
		end else begin
			cb_sum = pr_cb_hold + px.cb;
			cr_sum = pr_cr_hold + px.cr;
			if (pr_mode == MODE_422) begin
				r.fin = 1'b1;
			end else if (!px.odd) begin
				pr_store[idx] = {cr_sum[8:1], cb_sum[8:1]};
			end else begin
				entry  = pr_store[idx];
				cb_sum = cb_sum[8:1] + entry[7:0];
				cr_sum = cr_sum[8:1] + entry[15:8];
				pr_store[idx] = {cr_sum[8:1], cb_sum[8:1]};
				r.fin = 1'b1;
			end
			r.vld       = 1'b1;
			r.data.cb   = cb_sum[8:1];
			r.data.cr   = cr_sum[8:1];
			r.data.ccol = idx;
		end
		pr_col = column_after(pr_col, pr_width);
		return r;
	endfunction

	// queue one pixel; an odd-row pair never reads a store entry no even row wrote
	task automatic add_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr, logic odd);
		pixel_t px;
		if (gen_mode == MODE_420 && gen_col[0]) begin
			if (odd && !store_filled[gen_col[CCOL_W:1]])
				odd = 1'b0;
			if (!odd)
				store_filled[gen_col[CCOL_W:1]] = 1'b1;
		end
		px = '{odd: odd, cr: cr, cb: cb, luma: luma};
		pixel_q.push_back(px);
		pushed_total++;
		gen_col = column_after(gen_col, gen_width);
		if (gen_col == '0)
			gen_odd = ~gen_odd;
	endtask

	function automatic logic [7:0] chroma_sample();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hff;
		return 8'($urandom_range(255));
	endfunction

	// mostly line-ordered row parity, some noise
	task automatic add_random_pixels(int n);
		logic odd;
		for (int i = 0; i < n; i++) begin
			odd = ($urandom_range(99) < 15) ? 1'($urandom_range(1)) : gen_odd;
			add_pixel(8'($urandom_range(255)), chroma_sample(), chroma_sample(), odd);
		end
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// only called while the block is drained
	task automatic set_regs(logic [CFG_DATA_W-1:0] width, logic mode);
		write_reg(REG_LINE_WIDTH, width);
		write_reg(REG_SUBSAMPLE_MODE, mode);
		pr_width  = width;
		gen_width = width;
		pr_mode   = mode;
		gen_mode  = mode;
		settings_n++;
	endtask

	task automatic wait_drained();
		wait (words_in == pushed_total && words_out >= words_in);
	endtask

	// driver: offer queued pixels, predict each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				chroma_q.push_back(chroma_predict(offered));
				words_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pixel_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {offered.cr, offered.cb, offered.luma};
					s_axis_tuser  <= offered.odd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each output word against the oldest prediction
	chroma_word_t want, got;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_out++;
				got.data = out_data_t'(m_axis_tdata);
				got.vld  = m_axis_tuser[M_USER_VLD];
				got.fin  = m_axis_tuser[M_USER_FIN];
				if (chroma_q.size() == 0) begin
					if (fails < REPORT_LIMIT)
						$display("unexpected word %0d: data %h user %b",
							words_out, m_axis_tdata, m_axis_tuser);
					fails++;
				end else begin
					want = chroma_q.pop_front();
					if (want.vld && want.fin)
						final_n++;
					else if (want.vld)
						provisional_n++;
					if (got.data.luma !== want.data.luma || got.data.cb !== want.data.cb ||
						got.data.cr !== want.data.cr || got.data.ccol !== want.data.ccol ||
						got.data.pad !== want.data.pad || got.vld !== want.vld ||
						got.fin !== want.fin) begin
						if (fails < REPORT_LIMIT) begin
							$display("mismatch word %0d: expected luma %0d cb %0d cr %0d col %0d pad %0d valid %b final %b",
								words_out, want.data.luma, want.data.cb, want.data.cr,
								want.data.ccol, want.data.pad, want.vld, want.fin);
							$display("mismatch word %0d: got luma %0d cb %0d cr %0d col %0d pad %0d valid %b final %b",
								words_out, got.data.luma, got.data.cb, got.data.cr,
								got.data.ccol, got.data.pad, got.vld, got.fin);
						end
						fails++;
					end
				end
			end
			// one long hold-off so the block backs up into s_axis
			if (hold_armed && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 4:2:0, full and mixed extremes, then odd rows and a repeated odd row
		set_regs(13'd4, MODE_420);
		add_pixel(8'd0,   8'd0,   8'd255, 1'b0);
		add_pixel(8'd255, 8'd255, 8'd0,   1'b0);
		add_pixel(8'd128, 8'd255, 8'd255, 1'b0);
		add_pixel(8'd127, 8'd255, 8'd255, 1'b0);
		add_pixel(8'd1,   8'd0,   8'd0,   1'b1);
		add_pixel(8'd2,   8'd0,   8'd0,   1'b1);
		add_pixel(8'd3,   8'd255, 8'd255, 1'b1);
		add_pixel(8'd4,   8'd255, 8'd255, 1'b1);
		add_pixel(8'd5,   8'd1,   8'd1,   1'b1);
		add_pixel(8'd6,   8'd1,   8'd1,   1'b1);
		wait_drained();

		// directed: 4:2:2 with an odd width, trailing pixel left unpaired
		set_regs(13'd3, MODE_422);
		add_random_pixels(6);
		wait_drained();

		// directed: zero width acts as one, never pairs
		set_regs(13'd0, MODE_420);
		add_random_pixels(3);
		wait_drained();

		// directed: width above the maximum clamps
		set_regs(13'd5000, MODE_420);
		add_random_pixels(4);
		wait_drained();

		// random phases, mostly small widths
		for (int p = 0; p < 10; p++) begin
			if (p < 4) begin
				send_idle_pct = 16;
				recv_idle_pct = 71;
			end else if (p < 8) begin
				send_idle_pct = 71;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 4)
				w = MAX_W;
			else if ($urandom_range(9) == 0)
				w = $urandom_range(1, 3);
			else
				w = $urandom_range(1, 64);
			set_regs(13'(w), 1'($urandom_range(1)));
			if (p == 8)
				hold_armed = 1'b1;
			add_random_pixels($urandom_range(120, 180));
			wait_drained();
		end

		repeat (10) @(posedge clk);
		fails += chroma_q.size();
		$display("run: %0d pixels in, %0d words out, %0d register settings",
			words_in, words_out, settings_n);
		$display("run: %0d provisional and %0d final chroma pairs, %0d failures",
			provisional_n, final_n, fails);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### chroma_subsample_444_to_420.f
hdl/csub_pkg.sv
hdl/chroma_subsample_444_to_420.sv
hdl/csub_check.sv
tb/chroma_subsample_444_to_420_tb.sv
